@@ sv/kedl_pkg.sv @@
// shared constants and types for the knife-edge diffraction loss pipeline
package kedl_pkg;

  localparam logic [23:0] WAVE_RESET = 24'd333103;
  localparam logic [20:0] TWO_E6     = 21'd2000000;

  localparam int QBITS     = 46;  // quotient bits below the cap
  localparam int R1_STEPS  = 23;  // root of the quotient
  localparam int R2_STEPS  = 24;  // root of x^2 + 1
  localparam int LOG_STEPS = 16;  // fraction bits of log2

  localparam logic signed [23:0] NU_DEGEN   = -24'sd65536;
  localparam logic signed [23:0] NU_POS_SAT = 24'sh7FFFFF;
  localparam logic signed [23:0] NU_NEG_SAT = 24'sh800000;
  localparam logic signed [23:0] NU_CLEAR   = -24'sd51119;
  localparam logic signed [24:0] TENTH_Q16  = 25'sd6554;

  localparam logic signed [41:0] DB_PER_OCT = 42'sd394566;
  localparam logic signed [42:0] BASE_NUM   = 43'sd452198 <<< 16;
  localparam logic signed [42:0] ROUND_HALF = 43'sd1 <<< 23;

  typedef struct packed {
    logic neg;
    logic degen;
    logic cap;
  } front_t;

  typedef struct packed {
    logic signed [23:0] nu;
    logic               clear;
    logic               degen;
  } back_t;

endpackage

@@ sv/knife_edge_diffraction_loss.sv @@
// knife-edge diffraction loss: fresnel parameter and loss, fully pipelined
//
// input channel: in_valid / in_stall with obstacle_height (signed, 1/16 m),
// dist_first and dist_second (metres). a beat is taken when in_valid is high
// and in_stall is low. output channel: out_valid / out_stall with
// fresnel_param (signed Q8.16), loss_db (1/256 dB) and degenerate.
// the user writes wavelength_um through cfg_write / cfg_data only while no beat
// is in flight; the block does not enforce this. reset loads 333103 um.
// throughput is one beat per cycle while the skid register is empty. the
// pipeline runs 4 multiply stages (the first loaded at the accepting edge),
// 47 restoring divide stages, 24 root stages, 2 stages to form nu and x,
// 25 root stages, 2 normalize stages, 17 log2 squaring stages, 2 scaling
// stages, then the output register.
// synchronous reset clears every valid bit, out_valid and the skid valid included.
// when the receiver stalls, the result sits in the output register and one
// more beat lands in a skid register; only while the skid register is full
// does in_stall rise and the whole pipeline hold.
module knife_edge_diffraction_loss (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [16:0]  obstacle_height,
  input  logic [17:0]         dist_first,
  input  logic [17:0]         dist_second,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  fresnel_param,
  output logic [15:0]         loss_db,
  output logic                degenerate
);
  import kedl_pkg::*;

  logic [23:0] wavelength_um;
  logic        en;

  // input conditioning
  logic [16:0] h_raw, mag_in;
  logic [23:0] lam_in;

  // front stages
  logic        a_v, b_v, c_v, d_v;
  logic [16:0] a_mag;
  logic [18:0] a_sum;
  logic [17:0] a_d1, a_d2;
  logic [23:0] a_lam, b_lam;
  front_t      a_f, b_f, c_f, d_f;
  logic [32:0] b_sq;
  logic [39:0] b_bp;
  logic [35:0] b_p;
  logic [52:0] c_nlo, c_nhi;
  logic [41:0] c_dlo, c_dhi;
  logic [72:0] d_num;
  logic [59:0] d_den;

  // divider
  logic             dv_v   [0:QBITS];
  front_t           dv_f   [0:QBITS];
  logic [QBITS-1:0] dv_q   [0:QBITS];
  logic [59:0]      dv_r   [0:QBITS-1];
  logic [59:0]      dv_den [0:QBITS-1];
  logic [QBITS-1:0] dv_low [0:QBITS-1];
  logic             dv_ge  [1:QBITS];
  logic [59:0]      dv_r_next [1:QBITS];

  // first root
  logic        sa_v    [0:R1_STEPS];
  front_t      sa_f    [0:R1_STEPS];
  logic [46:0] sa_root [0:R1_STEPS];
  logic [46:0] sa_val  [0:R1_STEPS-1];
  logic        sa_ge   [1:R1_STEPS];
  logic [46:0] sa_t    [1:R1_STEPS];

  // nu and x
  logic              n_v, x_v;
  back_t             n_b, x_b;
  logic signed [23:0] nu_next;
  logic signed [24:0] x_next;
  logic              x_neg;
  logic [23:0]       x_ax;

  // second root
  logic        sb_v    [0:R2_STEPS];
  back_t       sb_b    [0:R2_STEPS];
  logic        sb_neg  [0:R2_STEPS];
  logic [23:0] sb_ax   [0:R2_STEPS];
  logic [48:0] sb_root [0:R2_STEPS];
  logic [48:0] sb_val  [0:R2_STEPS-1];
  logic        sb_ge   [1:R2_STEPS];
  logic [48:0] sb_t    [1:R2_STEPS];

  // normalize
  logic        s_v, z_v;
  back_t       s_b, z_b;
  logic [25:0] s_a, z_a;
  logic [4:0]  z_m, lead_pos;

  // log2
  logic              lg_v  [0:LOG_STEPS];
  back_t             lg_b  [0:LOG_STEPS];
  logic signed [5:0] lg_e  [0:LOG_STEPS];
  logic [15:0]       lg_fr [0:LOG_STEPS];
  logic [30:0]       lg_y  [0:LOG_STEPS-1];
  logic [61:0]       lg_p  [1:LOG_STEPS];
  logic signed [21:0] log_q16;

  // scaling
  logic              m_v, f_v;
  back_t             m_b, f_b;
  logic signed [41:0] m_prod;
  logic signed [42:0] f_num, f_rnd;
  logic [15:0]       res_loss;

  // skid
  logic              sk_v;
  logic signed [23:0] sk_nu;
  logic [15:0]       sk_loss;
  logic              sk_deg;

  assign en       = !sk_v;
  assign in_stall = sk_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      wavelength_um <= WAVE_RESET;
    end else if (cfg_write) begin
      wavelength_um <= cfg_data;
    end
  end

  assign h_raw  = obstacle_height;
  assign mag_in = h_raw[16] ? (~h_raw + 17'd1) : h_raw;
  assign lam_in = (wavelength_um == 24'd0) ? 24'd1 : wavelength_um;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0;
      n_v <= 1'b0; x_v <= 1'b0; s_v <= 1'b0; z_v <= 1'b0;
      m_v <= 1'b0; f_v <= 1'b0;
      for (int k = 0; k <= QBITS; k++) dv_v[k] <= 1'b0;
      for (int j = 0; j <= R1_STEPS; j++) sa_v[j] <= 1'b0;
      for (int j = 0; j <= R2_STEPS; j++) sb_v[j] <= 1'b0;
      for (int k = 0; k <= LOG_STEPS; k++) lg_v[k] <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      dv_v[0] <= d_v;
      for (int k = 1; k <= QBITS; k++) dv_v[k] <= dv_v[k-1];
      sa_v[0] <= dv_v[QBITS];
      for (int j = 1; j <= R1_STEPS; j++) sa_v[j] <= sa_v[j-1];
      n_v <= sa_v[R1_STEPS];
      x_v <= n_v;
      sb_v[0] <= x_v;
      for (int j = 1; j <= R2_STEPS; j++) sb_v[j] <= sb_v[j-1];
      s_v <= sb_v[R2_STEPS];
      z_v <= s_v;
      lg_v[0] <= z_v;
      for (int k = 1; k <= LOG_STEPS; k++) lg_v[k] <= lg_v[k-1];
      m_v <= lg_v[LOG_STEPS];
      f_v <= m_v;
    end
  end

  // ------------------------------------------------ products and quotient
  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= mag_in;
      a_sum <= 19'(dist_first) + 19'(dist_second);
      a_d1  <= dist_first;
      a_d2  <= dist_second;
      a_lam <= lam_in;
      a_f   <= '{neg: h_raw[16], degen: (dist_first == 18'd0) || (dist_second == 18'd0),
                 cap: 1'b0};

      b_sq  <= 33'(a_mag) * 33'(a_mag);
      b_bp  <= 40'(a_sum) * 40'(TWO_E6);
      b_p   <= 36'(a_d1) * 36'(a_d2);
      b_lam <= a_lam;
      b_f   <= a_f;

      // numerator and denominator split into half-width partial products
      c_nlo <= 53'(b_sq) * 53'(b_bp[19:0]);
      c_nhi <= 53'(b_sq) * 53'(b_bp[39:20]);
      c_dlo <= 42'(b_lam) * 42'(b_p[17:0]);
      c_dhi <= 42'(b_lam) * 42'(b_p[35:18]);
      c_f   <= b_f;

      d_num <= 73'(c_nlo) + (73'(c_nhi) << 20);
      d_den <= 60'(c_dlo) + (60'(c_dhi) << 18);
      d_f   <= c_f;
    end
  end

  // restoring divide of (num << 24) by den, one quotient bit per stage
  always_comb begin
    logic [60:0] rem2;
    for (int k = 1; k <= QBITS; k++) begin
      rem2 = {dv_r[k-1], dv_low[k-1][QBITS-1]};
      dv_ge[k] = rem2 >= {1'b0, dv_den[k-1]};
      dv_r_next[k] = dv_ge[k] ? 60'(rem2 - {1'b0, dv_den[k-1]}) : rem2[59:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // upper part already at or above den means the quotient hits the cap
      dv_r[0]   <= 60'(d_num[72:22]);
      dv_den[0] <= d_den;
      dv_low[0] <= {d_num[21:0], 24'd0};
      dv_q[0]   <= '0;
      dv_f[0]   <= '{neg: d_f.neg, degen: d_f.degen,
                     cap: ({9'd0, d_num[72:22]} >= d_den)};
      for (int k = 1; k < QBITS; k++) begin
        dv_r[k]   <= dv_r_next[k];
        dv_den[k] <= dv_den[k-1];
        dv_low[k] <= {dv_low[k-1][QBITS-2:0], 1'b0};
      end
      for (int k = 1; k <= QBITS; k++) begin
        dv_q[k] <= {dv_q[k-1][QBITS-2:0], dv_ge[k]};
        dv_f[k] <= dv_f[k-1];
      end
    end
  end

  // ------------------------------------------------------------ first root
  always_comb begin
    for (int j = 1; j <= R1_STEPS; j++) begin
      sa_t[j]  = sa_root[j-1] + (47'd1 << (46 - 2 * j));
      sa_ge[j] = sa_val[j-1] >= sa_t[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_val[0]  <= 47'(dv_q[QBITS]);
      sa_root[0] <= '0;
      sa_f[0]    <= dv_f[QBITS];
      for (int j = 1; j <= R1_STEPS; j++) begin
        sa_root[j] <= sa_ge[j] ? (sa_root[j-1] >> 1) + (47'd1 << (46 - 2 * j))
                               : (sa_root[j-1] >> 1);
        sa_f[j]    <= sa_f[j-1];
      end
      for (int j = 1; j < R1_STEPS; j++) begin
        sa_val[j] <= sa_ge[j] ? sa_val[j-1] - sa_t[j] : sa_val[j-1];
      end
    end
  end

  // ------------------------------------------------------------ nu and x
  always_comb begin
    logic [23:0] root_ext;
    root_ext = {1'b0, sa_root[R1_STEPS][22:0]};
    if (sa_f[R1_STEPS].degen) begin
      nu_next = NU_DEGEN;
    end else if (sa_f[R1_STEPS].cap) begin
      nu_next = sa_f[R1_STEPS].neg ? NU_NEG_SAT : NU_POS_SAT;
    end else if (sa_f[R1_STEPS].neg) begin
      nu_next = -$signed(root_ext);
    end else begin
      nu_next = $signed(root_ext);
    end
  end

  assign x_next = 25'(n_b.nu) - TENTH_Q16;

  always_ff @(posedge clk) begin
    if (en) begin
      n_b   <= '{nu: nu_next, clear: 1'b0, degen: sa_f[R1_STEPS].degen};
      x_b   <= '{nu: n_b.nu, clear: n_b.degen || (n_b.nu <= NU_CLEAR), degen: n_b.degen};
      x_neg <= x_next[24];
      x_ax  <= x_next[24] ? 24'(-x_next) : 24'(x_next);
    end
  end

  // ----------------------------------------------- second root: sqrt(x^2+1)
  always_comb begin
    for (int j = 1; j <= R2_STEPS; j++) begin
      sb_t[j]  = sb_root[j-1] + (49'd1 << (48 - 2 * j));
      sb_ge[j] = sb_val[j-1] >= sb_t[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_val[0]  <= 49'(x_ax) * 49'(x_ax) + (49'd1 << 32);
      sb_root[0] <= '0;
      sb_b[0]    <= x_b;
      sb_neg[0]  <= x_neg;
      sb_ax[0]   <= x_ax;
      for (int j = 1; j <= R2_STEPS; j++) begin
        sb_root[j] <= sb_ge[j] ? (sb_root[j-1] >> 1) + (49'd1 << (48 - 2 * j))
                               : (sb_root[j-1] >> 1);
        sb_b[j]    <= sb_b[j-1];
        sb_neg[j]  <= sb_neg[j-1];
        sb_ax[j]   <= sb_ax[j-1];
      end
      for (int j = 1; j < R2_STEPS; j++) begin
        sb_val[j] <= sb_ge[j] ? sb_val[j-1] - sb_t[j] : sb_val[j-1];
      end
    end
  end

  // ---------------------------------------------------- normalize for log2
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < 26; i++) begin
      if (s_a[i]) lead_pos = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a <= sb_neg[R2_STEPS] ? 26'(sb_root[R2_STEPS][24:0]) - 26'(sb_ax[R2_STEPS])
                              : 26'(sb_root[R2_STEPS][24:0]) + 26'(sb_ax[R2_STEPS]);
      s_b <= sb_b[R2_STEPS];
      z_a <= s_a;
      z_m <= lead_pos;
      z_b <= s_b;
    end
  end

  // ---------------------------------------- log2 fraction by squaring, Q.30
  always_comb begin
    for (int k = 1; k <= LOG_STEPS; k++) begin
      lg_p[k] = 62'(lg_y[k-1]) * 62'(lg_y[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_y[0]  <= 31'({5'd0, z_a} << (5'd30 - z_m));
      lg_e[0]  <= $signed(6'(z_m) - 6'd16);
      lg_fr[0] <= '0;
      lg_b[0]  <= z_b;
      for (int k = 1; k <= LOG_STEPS; k++) begin
        lg_e[k]  <= lg_e[k-1];
        lg_fr[k] <= {lg_fr[k-1][14:0], lg_p[k][61]};
        lg_b[k]  <= lg_b[k-1];
      end
      for (int k = 1; k < LOG_STEPS; k++) begin
        // square at or above 2.0 gives a one bit and halves
        lg_y[k] <= lg_p[k][61] ? lg_p[k][61:31] : lg_p[k][60:30];
      end
    end
  end

  // ------------------------------------------------------ scale to 1/256 dB
  assign log_q16 = $signed({lg_e[LOG_STEPS], lg_fr[LOG_STEPS]});

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= 42'(log_q16) * DB_PER_OCT;
      m_b    <= lg_b[LOG_STEPS];
      f_num  <= BASE_NUM + 43'(m_prod);
      f_b    <= m_b;
    end
  end

  assign f_rnd = f_num + ROUND_HALF;

  always_comb begin
    if (f_b.clear || (f_num <= 43'sd0)) begin
      res_loss = '0;
    end else if (f_rnd[42:40] != 3'd0) begin
      res_loss = 16'hFFFF;
    end else begin
      res_loss = f_rnd[39:24];
    end
  end

  // ------------------------------------------------------- output and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (!sk_v) begin
      if (f_v) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end else begin
          sk_v <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end else if (!out_stall) begin
      sk_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v && f_v) begin
      if (!out_valid || !out_stall) begin
        fresnel_param <= f_b.nu;
        loss_db       <= res_loss;
        degenerate    <= f_b.degen;
      end else begin
        sk_nu   <= f_b.nu;
        sk_loss <= res_loss;
        sk_deg  <= f_b.degen;
      end
    end else if (sk_v && !out_stall) begin
      fresnel_param <= sk_nu;
      loss_db       <= sk_loss;
      degenerate    <= sk_deg;
    end
  end

  // ------------------------------------------------------------ assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_valid)
    else $error("skid register full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_v) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output beat");

  a_degen_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (fresnel_param == NU_DEGEN && loss_db == 16'd0))
    else $error("degenerate beat without forced nu and zero loss");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    (sk_v && $past(sk_v)) |-> $stable(f_num))
    else $error("pipeline moved while skid register full");

endmodule

@@ test/knife_edge_diffraction_loss_tb.sv @@
// testbench for the knife-edge diffraction loss pipeline with its own loss predictor
`timescale 1ns / 100ps

module knife_edge_diffraction_loss_tb;
  import kedl_pkg::*;

  typedef struct {
    logic signed [23:0] nu;
    logic [15:0]        loss;
    logic               degen;
  } loss_result_t;

  class loss_tracker;
    loss_result_t pending_results[$];
    logic [23:0]  wavelength;
    int           errors;

    function new();
      wavelength = WAVE_RESET;
      errors = 0;
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // log2(a / 2^16) in Q.16, fraction by repeated squaring
    static function longint log2_q16(longint unsigned a);
      int lead;
      longint unsigned y;
      longint fr;
      lead = 63;
      fr = 0;
      while (lead > 0 && a[lead] == 1'b0) lead--;
      y = (lead >= 30) ? (a >> (lead - 30)) : (a << (30 - lead));
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          fr = fr * 2 + 1;
        end else begin
          fr = fr * 2;
        end
      end
      return longint'(lead - 16) * 65536 + fr;
    endfunction

    static function logic [15:0] loss_from_nu(longint nu);
      longint x, num, outv;
      longint unsigned ax, s, a;
      if (nu <= longint'(NU_CLEAR)) return 16'd0;
      x = nu - longint'(TENTH_Q16);
      ax = (x < 0) ? -x : x;
      s = int_root(ax * ax + (64'd1 << 32));
      a = (x < 0) ? s - ax : s + ax;
      if (a == 0) return 16'd0;
      num = longint'(BASE_NUM) + longint'(DB_PER_OCT) * log2_q16(a);
      if (num <= 0) return 16'd0;
      outv = (num + (64'sd1 <<< 23)) >>> 24;
      return (outv > 65535) ? 16'hFFFF : outv[15:0];
    endfunction

    function void note_beat(logic signed [16:0] h, logic [17:0] d1, logic [17:0] d2);
      loss_result_t r;
      longint unsigned mag, lam, den, root;
      logic [127:0] prod, quot;
      mag = (h < 0) ? longint'(-longint'(h)) : longint'(h);
      lam = (wavelength == 0) ? 1 : wavelength;
      if (d1 == 0 || d2 == 0) begin
        r.nu = NU_DEGEN;
        r.loss = 16'd0;
        r.degen = 1'b1;
      end else begin
        prod = (128'(mag * mag) * 128'((64'(d1) + 64'(d2)) * 64'd2000000)) << 24;
        den = lam * 64'(d1) * 64'(d2);
        quot = prod / 128'(den);
        if (quot > (128'd1 << 46)) quot = 128'd1 << 46;
        root = int_root(quot[63:0]);
        if (h < 0) r.nu = (root >= (64'd1 << 23)) ? NU_NEG_SAT : -24'(root);
        else r.nu = (root >= (64'd1 << 23)) ? NU_POS_SAT : 24'(root);
        r.loss = loss_from_nu(longint'(r.nu));
        r.degen = 1'b0;
      end
      pending_results.push_back(r);
    endfunction

    function void check_beat(logic signed [23:0] nu, logic [15:0] loss, logic degen);
      loss_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat nu=%0d loss=%0d degenerate=%0d",
                 $time, nu, loss, degen);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (nu !== e.nu) begin
        $display("%0t: fresnel_param expected %0d actual %0d", $time, e.nu, nu);
        errors++;
      end
      if (loss !== e.loss) begin
        $display("%0t: loss_db expected %0d actual %0d", $time, e.loss, loss);
        errors++;
      end
      if (degen !== e.degen) begin
        $display("%0t: degenerate expected %0d actual %0d", $time, e.degen, degen);
        errors++;
      end
    endfunction
  endclass

  localparam int PIPE_DEPTH = 130;
  localparam int STALL_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [16:0] obstacle_height;
  logic [17:0]        dist_first;
  logic [17:0]        dist_second;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] fresnel_param;
  logic [15:0]        loss_db;
  logic               degenerate;

  loss_tracker tracker = new();
  bit steady;      // no idling on either side
  bit hold_output; // request a long receiver hold-off
  int idle_count;

  knife_edge_diffraction_loss dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .obstacle_height(obstacle_height),
    .dist_first(dist_first), .dist_second(dist_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .fresnel_param(fresnel_param), .loss_db(loss_db), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) tracker.note_beat(obstacle_height, dist_first, dist_second);
    if (!rst && out_valid && !out_stall) tracker.check_beat(fresnel_param, loss_db, degenerate);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_output = 1'b0;
        out_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15) - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic signed [16:0] h, logic [17:0] d1, logic [17:0] d2, bit no_gap);
    int gap;
    gap = (steady || no_gap || $urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    obstacle_height <= h;
    dist_first <= d1;
    dist_second <= d2;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_wavelength(logic [23:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.wavelength = v;
  endtask

  // sender pause until every result is back, then let the pipe go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  function automatic logic [17:0] any_distance();
    if ($urandom_range(0, 24) == 0) return 18'd0;
    return 18'($urandom_range(1, (1 << $urandom_range(1, 18)) - 1));
  endfunction

  task automatic send_random(int count, bit no_gap);
    logic signed [16:0] h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) h = 17'($urandom);
      else begin
        h = 17'($urandom_range(0, (1 << $urandom_range(1, 16)) - 1));
        if ($urandom_range(0, 1)) h = -h;
      end
      send_beat(h, any_distance(), any_distance(), no_gap);
    end
  endtask

  initial begin
    rst = 1'b1;
    steady = 1'b0;
    hold_output = 1'b0;
    idle_count = 0;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    obstacle_height = '0;
    dist_first = '0;
    dist_second = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, zero distances, zero height, saturation, clearance
    send_beat(17'sd0, 18'd1000, 18'd1000, 0);
    send_beat(17'sd65535, 18'd1, 18'd1, 0);
    send_beat(-17'sd65536, 18'd1, 18'd1, 0);
    send_beat(17'sd65535, 18'd262143, 18'd262143, 0);
    send_beat(-17'sd65536, 18'd262143, 18'd262143, 0);
    send_beat(17'sd1, 18'd262143, 18'd262143, 0);
    send_beat(-17'sd1, 18'd262143, 18'd262143, 0);
    send_beat(17'sd100, 18'd0, 18'd500, 0);
    send_beat(17'sd100, 18'd500, 18'd0, 0);
    send_beat(-17'sd100, 18'd0, 18'd0, 0);
    send_beat(17'sd160, 18'd5000, 18'd5000, 0);
    send_beat(-17'sd160, 18'd5000, 18'd5000, 0);
    send_beat(-17'sd100, 18'd5000, 18'd5000, 0);
    send_beat(-17'sd120, 18'd5000, 18'd5000, 0);
    send_beat(17'sd40, 18'd2000, 18'd3000, 0);
    send_beat(-17'sd30000, 18'd10, 18'd20, 0);
    send_random(60, 0);
    drain();

    set_wavelength(24'd1);
    send_random(90, 0);
    drain();

    set_wavelength(24'hFFFFFF);
    send_random(90, 0);
    drain();

    // long receiver hold-off while the sender keeps pushing, pipe fills up
    set_wavelength(24'd3000000);
    hold_output = 1'b1;
    send_random(200, 1);
    drain();

    set_wavelength(24'd0);
    send_random(60, 0);
    drain();

    set_wavelength(24'($urandom_range(1, 24'hFFFFFF)));
    send_random(100, 0);
    drain();

    steady = 1'b1;
    set_wavelength(24'd125000);
    send_random(120, 0);
    drain();

    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
